### src/kfts_pkg.sv
package kfts_pkg;

  // Sequencer micro-operations executed by the shared datapath.
  typedef enum logic [3:0] {
    OP_MULDT  = 4'd0,  // acc = round(a * dt / 2^8)
    OP_MULF   = 4'd1,  // acc = round(a * b / 2^FRAC)
    OP_ADD    = 4'd2,  // acc = sat(a + b)
    OP_SUB    = 4'd3,  // acc = sat(a - b)
    OP_DIV    = 4'd4,  // acc = round(a * 2^FRAC / b)
    OP_MOVE   = 4'd5   // acc = a
  } op_t;

  // Register file slots of the sequencer.
  typedef enum logic [4:0] {
    R_X0 = 5'd0, R_X1 = 5'd1, R_P0 = 5'd2, R_P1 = 5'd3, R_P2 = 5'd4, R_P3 = 5'd5,
    R_Q = 5'd6, R_RN = 5'd7, R_Z = 5'd8, R_X0P = 5'd9, R_AP00 = 5'd10,
    R_AP01 = 5'd11, R_M00 = 5'd12, R_M10 = 5'd13, R_M11 = 5'd14, R_S = 5'd15,
    R_K0 = 5'd16, R_K1 = 5'd17, R_Y = 5'd18, R_T = 5'd19, R_ZERO = 5'd20
  } reg_t;

  localparam int NUM_REGS = 21;

  typedef struct packed {
    op_t  op;
    reg_t src_a;
    reg_t src_b;
    reg_t dst;
  } uop_t;

  localparam int NUM_UOPS = 27;

  // Program: prediction, gain, update. Gain divisions are skipped if S <= 0 (K stays 0).
  function automatic uop_t prog(input logic [4:0] pc);
    uop_t u;
    u = '{OP_MOVE, R_ZERO, R_ZERO, R_T};
    case (pc)
      5'd0:  u = '{OP_MULDT, R_X1, R_ZERO, R_T};
      5'd1:  u = '{OP_ADD, R_X0, R_T, R_X0P};
      5'd2:  u = '{OP_MULDT, R_P2, R_ZERO, R_T};
      5'd3:  u = '{OP_ADD, R_P0, R_T, R_AP00};
      5'd4:  u = '{OP_MULDT, R_P3, R_ZERO, R_T};
      5'd5:  u = '{OP_ADD, R_P1, R_T, R_AP01};
      5'd6:  u = '{OP_ADD, R_P2, R_T, R_M10};
      5'd7:  u = '{OP_MULDT, R_AP01, R_ZERO, R_T};
      5'd8:  u = '{OP_ADD, R_AP00, R_T, R_T};
      5'd9:  u = '{OP_ADD, R_T, R_Q, R_M00};
      5'd10: u = '{OP_ADD, R_P3, R_Q, R_M11};
      5'd11: u = '{OP_ADD, R_M00, R_RN, R_S};
      5'd12: u = '{OP_MOVE, R_ZERO, R_ZERO, R_K0};
      5'd13: u = '{OP_MOVE, R_ZERO, R_ZERO, R_K1};
      5'd14: u = '{OP_DIV, R_M00, R_S, R_K0};
      5'd15: u = '{OP_DIV, R_M10, R_S, R_K1};
      5'd16: u = '{OP_SUB, R_Z, R_X0P, R_Y};
      5'd17: u = '{OP_MULF, R_K0, R_Y, R_T};
      5'd18: u = '{OP_ADD, R_X0P, R_T, R_X0};
      5'd19: u = '{OP_MULF, R_K1, R_Y, R_T};
      5'd20: u = '{OP_ADD, R_X1, R_T, R_X1};
      5'd21: u = '{OP_MULF, R_K0, R_AP01, R_T};
      5'd22: u = '{OP_SUB, R_AP01, R_T, R_P1};
      5'd23: u = '{OP_MULF, R_K1, R_AP01, R_T};
      5'd24: u = '{OP_SUB, R_M11, R_T, R_P3};
      5'd25: u = '{OP_MULF, R_K1, R_M00, R_T};
      5'd26: u = '{OP_SUB, R_M10, R_T, R_P2};
      default: u = '{OP_MOVE, R_ZERO, R_ZERO, R_T};
    endcase
    return u;
  endfunction

  // Final P00 update is appended by the sequencer after the program.
  localparam logic [4:0] PC_DIV_FIRST  = 5'd14;
  localparam logic [4:0] PC_AFTER_DIV  = 5'd16;

  localparam logic [1:0] ADDR_TIME_STEP  = 2'd0;
  localparam logic [1:0] ADDR_PROC_NOISE = 2'd1;
  localparam logic [1:0] ADDR_MEAS_NOISE = 2'd2;
  localparam logic [1:0] ADDR_INIT_COV   = 2'd3;

endpackage

### src/kfts_alu.sv
// Shared arithmetic unit: one saturating add/sub, one multiplier worked as
// 16x16 partial products summed in turn, and a bit-serial restoring divider.
module kfts_alu import kfts_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int STATE_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  op_t                           op,
  input  logic signed [STATE_WIDTH-1:0] a,
  input  logic signed [STATE_WIDTH-1:0] b,
  input  logic [15:0]                   dt,
  output logic                          done,
  output logic signed [STATE_WIDTH-1:0] result
);

  localparam int W    = STATE_WIDTH;
  localparam int NCH  = (W + 15) / 16;
  localparam int MW   = NCH * 16;
  localparam int PW   = 2 * MW + 2;
  localparam int DW   = W + FRAC_BITS + 1;
  localparam int CW   = $clog2(DW + 1) + 1;
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_FIN = 4'b1000
  } st_t;

  st_t           st;
  op_t           op_r;
  logic          neg;
  logic [MW-1:0] ma, mb;
  logic [PW-1:0] prod;
  logic [CW-1:0] cnt;
  logic [$clog2(NCH+1)-1:0] ia, ib;
  logic [DW-1:0] num;
  logic [W:0]    rem;
  logic [DW-1:0] quo;
  logic [W-1:0]  dvs;

  logic [W:0]    sum_ext;
  logic [W-1:0]  sum_sat;
  logic [W:0]    mag_a, mag_b;
  logic [15:0]   chunk_a, chunk_b;
  logic [31:0]   pp;
  logic [PW-1:0] pp_sh;
  logic [W:0]    rem_sh;
  logic [PW-1:0] rnd_prod;
  logic [PW-1:0] shifted;
  logic [W:0]    limit;
  logic [W-1:0]  mag_fin;
  logic [W-1:0]  fin;

  assign mag_a = a[W-1] ? -{a[W-1], a} : {1'b0, a};
  assign mag_b = b[W-1] ? -{b[W-1], b} : {1'b0, b};

  // Combinational saturating add or subtract.
  always_comb begin
    if (op == OP_SUB) sum_ext = {a[W-1], a} - {b[W-1], b};
    else sum_ext = {a[W-1], a} + {b[W-1], b};
    if (sum_ext[W] != sum_ext[W-1]) sum_sat = sum_ext[W] ? SMIN : SMAX;
    else sum_sat = sum_ext[W-1:0];
  end

  assign chunk_a = ma[ia[$clog2(NCH)-1:0]*16 +: 16];
  assign chunk_b = mb[ib[$clog2(NCH)-1:0]*16 +: 16];
  assign pp      = chunk_a * chunk_b;
  assign pp_sh   = PW'(pp) << ((32'(ia) + 32'(ib)) * 16);
  assign rem_sh  = {rem[W-1:0], num[DW-1]};

  // Rounding shift and saturation of the product magnitude.
  always_comb begin
    if (op_r == OP_MULDT) begin
      rnd_prod = prod + (PW'(1) << 7);
      shifted  = rnd_prod >> 8;
    end else begin
      rnd_prod = prod + (PW'(1) << (FRAC_BITS - 1));
      shifted  = rnd_prod >> FRAC_BITS;
    end
    limit = neg ? {1'b0, SMIN} : {1'b0, SMAX};
    if (op_r == OP_DIV) begin
      if ((DW > W + 1 && |(quo >> (W + 1))) || ({1'b0, quo[W:0]} > {1'b0, limit}))
        mag_fin = limit[W-1:0];
      else mag_fin = quo[W-1:0];
    end else begin
      if (|(shifted >> (W + 1)) || (shifted[W:0] > limit)) mag_fin = limit[W-1:0];
      else mag_fin = shifted[W-1:0];
    end
    fin = neg ? -mag_fin : mag_fin;
  end

  // Sequencing of the multi-cycle operations.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            op_r <= op;
            if (op == OP_ADD || op == OP_SUB) begin
              result <= sum_sat;
              done   <= 1'b1;
            end else if (op == OP_MOVE) begin
              result <= a;
              done   <= 1'b1;
            end else if (op == OP_DIV) begin
              neg <= a[W-1];
              num <= (DW'(mag_a) << FRAC_BITS) + DW'(b[W-1:1]);
              dvs <= b;
              rem <= '0;
              quo <= '0;
              cnt <= '0;
              st  <= S_DIV;
            end else begin
              neg  <= (op == OP_MULDT) ? a[W-1] : (a[W-1] ^ b[W-1]);
              ma   <= MW'(mag_a);
              mb   <= (op == OP_MULDT) ? MW'(dt) : MW'(mag_b);
              prod <= '0;
              ia   <= '0;
              ib   <= '0;
              st   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod <= prod + pp_sh;
          if (32'(ib) == NCH - 1) begin
            ib <= '0;
            if (32'(ia) == NCH - 1) st <= S_FIN;
            else ia <= ia + 1'b1;
          end else begin
            ib <= ib + 1'b1;
          end
        end
        S_DIV: begin
          num <= num << 1;
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= rem_sh - {1'b0, dvs};
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DW-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (32'(cnt) == DW - 1) st <= S_FIN;
        end
        S_FIN: begin
          result <= fin;
          done   <= 1'b1;
          st     <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### src/kalman_filter_two_state_core.sv
// Two-state constant-velocity Kalman filter on a speed sample. Each request
// is processed by a microprogram on one shared add/multiply/divide unit. The
// gain divisions run only when the innovation variance is positive. Each
// multiply sums NCH*NCH 16-bit partial products, and each division produces
// STATE_WIDTH + FRAC_BITS + 1 quotient bits. in_ready is low while a request
// is in progress; the next request can be taken once the result is registered.
// The result waits in an output register until taken. Registers over APB:
// 0x0 time_step (Q8.8), 0x4 process_noise, 0x8 measurement_noise,
// 0xC initial_covariance (a write reloads the covariance).
module kalman_filter_two_state_core import kfts_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int STATE_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] measured_rpm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] filtered_rpm,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W = STATE_WIDTH;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001, C_ISSUE = 4'b0010, C_WAIT = 4'b0100, C_OUT = 4'b1000
  } cst_t;

  cst_t cst;
  logic [4:0] pc;
  logic [5:0] tail;
  logic [15:0] time_step, process_noise, measurement_noise, initial_covariance;
  logic signed [W-1:0] rf [NUM_REGS];
  logic signed [W-1:0] a_op, b_op, alu_res;
  logic alu_start, alu_done;
  uop_t uop;
  logic [4:0] pc_next;
  logic cfg_wr;
  logic signed [W-1:0] init_cov_state;
  logic [W:0] x0_round;

  // Integer register value to state format, saturating.
  function automatic logic signed [W-1:0] to_state(input logic [15:0] v);
    logic [W+15:0] x;
    x = (W+16)'(v) << FRAC_BITS;
    if (x > (W+16)'(SMAX)) return SMAX;
    return x[W-1:0];
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign init_cov_state = to_state(pwdata[15:0]);

  always_comb begin
    case (paddr[3:2])
      ADDR_TIME_STEP:  prdata = {16'd0, time_step};
      ADDR_PROC_NOISE: prdata = {16'd0, process_noise};
      ADDR_MEAS_NOISE: prdata = {16'd0, measurement_noise};
      ADDR_INIT_COV:   prdata = {16'd0, initial_covariance};
      default:         prdata = '0;
    endcase
  end

  // The last step (P00 = M00 - K0*M00) runs after the program as a tail.
  always_comb begin
    if (tail == 6'd1) uop = '{OP_MULF, R_K0, R_M00, R_T};
    else if (tail == 6'd2) uop = '{OP_SUB, R_M00, R_T, R_P0};
    else uop = prog(pc);
  end

  assign a_op = rf[uop.src_a];
  assign b_op = rf[uop.src_b];
  assign alu_start = (cst == C_ISSUE);
  assign in_ready = (cst == C_IDLE);

  kfts_alu #(.FRAC_BITS(FRAC_BITS), .STATE_WIDTH(STATE_WIDTH)) u_alu (
    .clk(clk), .rst(rst), .start(alu_start), .op(uop.op), .a(a_op), .b(b_op),
    .dt(time_step), .done(alu_done), .result(alu_res)
  );

  // Next program step; the divisions are skipped when S is not positive.
  always_comb begin
    pc_next = pc + 5'd1;
    if (pc_next == PC_DIV_FIRST && (rf[R_S][W-1] || rf[R_S] == '0))
      pc_next = PC_AFTER_DIV;
  end

  // Sequencer, register file and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      cst <= C_IDLE;
      out_valid <= 1'b0;
      pc <= '0;
      tail <= '0;
      time_step <= 16'd256;
      process_noise <= 16'd100;
      measurement_noise <= 16'd25;
      initial_covariance <= 16'd100;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i == R_P0 || i == R_P3) rf[i] <= to_state(16'd100);
        else rf[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          ADDR_TIME_STEP:  time_step <= pwdata[15:0];
          ADDR_PROC_NOISE: process_noise <= pwdata[15:0];
          ADDR_MEAS_NOISE: measurement_noise <= pwdata[15:0];
          ADDR_INIT_COV: begin
            initial_covariance <= pwdata[15:0];
            rf[R_P0] <= init_cov_state;
            rf[R_P1] <= '0;
            rf[R_P2] <= '0;
            rf[R_P3] <= init_cov_state;
          end
          default: ;
        endcase
      end
      case (cst)
        C_IDLE: begin
          if (in_valid) begin
            rf[R_Z]  <= to_state(measured_rpm);
            rf[R_Q]  <= to_state(process_noise);
            rf[R_RN] <= to_state(measurement_noise);
            pc <= '0;
            tail <= '0;
            cst <= C_ISSUE;
          end
        end
        C_ISSUE: cst <= C_WAIT;
        C_WAIT: begin
          if (alu_done) begin
            rf[uop.dst] <= alu_res;
            cst <= C_ISSUE;
            if (tail == 6'd2) begin
              cst <= C_OUT;
            end else if (tail != '0) begin
              tail <= tail + 6'd1;
            end else if (32'(pc) == NUM_UOPS - 1) begin
              tail <= 6'd1;
            end else begin
              pc <= pc_next;
            end
          end
        end
        C_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            cst <= C_IDLE;
          end
        end
        default: cst <= C_IDLE;
      endcase
      if (out_valid && out_ready && cst != C_OUT) out_valid <= 1'b0;
    end
  end

  // Value rounded to an integer, computed one bit wider so it cannot wrap.
  assign x0_round = ({1'b0, rf[R_X0]} + ((W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

  // Rounded, saturated output value.
  always_ff @(posedge clk) begin
    if (cst == C_OUT && (!out_valid || out_ready)) begin
      if (rf[R_X0][W-1] || rf[R_X0] == '0) filtered_rpm <= '0;
      else if (x0_round > (W+1)'(65535)) filtered_rpm <= 16'hFFFF;
      else filtered_rpm <= x0_round[15:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (cst != C_IDLE) |-> !in_ready) else $error("ready while busy");
  a_one_state: assert property (@(posedge clk) disable iff (rst)
    $onehot(cst)) else $error("state not one-hot");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (cst == C_WAIT)) else $error("unit result outside wait");
`endif

endmodule
